[design/opsq_pkg.sv]
// ----------------------------------------------------------------------------
// opsq_pkg
// Shared constants and types for the operating point stability qualifier.
// ----------------------------------------------------------------------------
package opsq_pkg;

  localparam int unsigned SpeedW      = 16;
  localparam int unsigned SpeedStoreW = 13;
  localparam int unsigned LoadW       = 16;
  localparam int unsigned LaunchW     = 8;
  localparam int unsigned CountW      = 9;
  localparam int unsigned CoarseW     = 8;
  localparam int unsigned SpeedUnitSh = 5;   // one coarse step is 32 speed counts

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [SpeedStoreW-1:0] SpeedStoreMax = 13'd8191;
  localparam logic [CountW-1:0]      CountMax      = 9'd499;

  localparam logic [CfgAddrW-1:0] CfgSpeedThr  = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgLoadThr   = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgDelay     = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgMinSpeed  = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgAutoGear  = 3'd4;

  typedef struct packed {
    logic               fault_inhibit;
    logic               critical_zone;
    logic [LaunchW-1:0] launch_inhibit_count;
    logic               acquisition_inhibit;
    logic               gear_changing;
    logic [LoadW-1:0]   air_load;
    logic [SpeedW-1:0]  engine_speed;
  } event_t;

  typedef struct packed {
    logic              adapt_enable;
    logic [CountW-1:0] stable_count;
    logic              engine_stable;
    logic              load_stable;
    logic              speed_stable;
  } result_t;

endpackage

[design/operating_point_stability_qualifier_unit.sv]
// ----------------------------------------------------------------------------
// operating_point_stability_qualifier_unit
// Qualifies speed/load stability per engine event and gates knock adaptation.
// ----------------------------------------------------------------------------
//  channel   dir  tdata bits (low to high)
//  s_axis    in   speed 16, load 16, gear_chg 1, acq_inh 1, launch 8,
//                 crit_zone 1, fault_inh 1, zero pad 4
//  m_axis    out  speed_ok 1, load_ok 1, eng_ok 1, count 9, adapt 1, pad 3
//  cfg       in   we, 3-bit index, 16-bit data; write only
//
//  Input register, then result register; one event per cycle sustained
//  while m_axis_tready_i is high.
//  Reset clears config, history and counter to zero.
//  A stall on m_axis fills the input register, then drops s_axis_tready_o.
// ----------------------------------------------------------------------------
module operating_point_stability_qualifier_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [opsq_pkg::InDataW-1:0]   s_axis_tdata_i,   // see table above
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [opsq_pkg::OutDataW-1:0]  m_axis_tdata_o,   // see table above
  input  logic                           cfg_we_i,
  input  logic [opsq_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [opsq_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import opsq_pkg::*;

  logic [15:0]       speed_thr_q, load_thr_q, delay_q;
  logic [CoarseW-1:0] min_speed_q;
  logic              auto_gear_q;

  event_t            ev_q;
  logic              ev_vld_q;
  result_t           res_q;
  logic              res_vld_q;

  logic [SpeedStoreW-1:0] prev_speed_q;
  logic [LoadW-1:0]       prev_load_q;
  logic [CountW-1:0]      cnt_q;

  logic              advance;
  logic [SpeedW-1:0] speed_ext, speed_diff, load_diff;
  logic [SpeedW-1:0] min_speed_full;
  logic              spd_ok, load_ok, adapt;
  logic [CountW-1:0] reload, cnt_d;
  logic [SpeedStoreW-1:0] prev_speed_d;

  assign advance         = ev_vld_q && (!res_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !ev_vld_q || advance;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_thr_q <= '0;
      load_thr_q  <= '0;
      delay_q     <= '0;
      min_speed_q <= '0;
      auto_gear_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgSpeedThr: speed_thr_q <= cfg_wdata_i;
        CfgLoadThr:  load_thr_q  <= cfg_wdata_i;
        CfgDelay:    delay_q     <= cfg_wdata_i;
        CfgMinSpeed: min_speed_q <= cfg_wdata_i[CoarseW-1:0];
        CfgAutoGear: auto_gear_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      ev_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      ev_q <= event_t'(s_axis_tdata_i[$bits(event_t)-1:0]);
    end
  end

  // qualification logic
  always_comb begin
    speed_ext  = {{(SpeedW-SpeedStoreW){1'b0}}, prev_speed_q};
    speed_diff = (ev_q.engine_speed >= speed_ext) ? ev_q.engine_speed - speed_ext
                                                  : speed_ext - ev_q.engine_speed;
    load_diff  = (ev_q.air_load >= prev_load_q) ? ev_q.air_load - prev_load_q
                                                : prev_load_q - ev_q.air_load;
    spd_ok  = speed_diff <= speed_thr_q;
    load_ok = load_diff <= load_thr_q;

    prev_speed_d = (ev_q.engine_speed > {{(SpeedW-SpeedStoreW){1'b0}}, SpeedStoreMax})
                   ? SpeedStoreMax : ev_q.engine_speed[SpeedStoreW-1:0];

    reload = (delay_q > {{(16-CountW){1'b0}}, CountMax}) ? CountMax
                                                         : delay_q[CountW-1:0];
    if (spd_ok && load_ok) begin
      cnt_d = (cnt_q != '0) ? cnt_q - 1'b1 : '0;
    end else begin
      cnt_d = reload;
    end

    min_speed_full = {{(SpeedW-CoarseW-SpeedUnitSh){1'b0}}, min_speed_q,
                      {SpeedUnitSh{1'b0}}};
    adapt = !ev_q.acquisition_inhibit && ev_q.critical_zone
         && (ev_q.launch_inhibit_count == '0)
         && (!ev_q.gear_changing || !auto_gear_q)
         && (ev_q.engine_speed >= min_speed_full)
         && !ev_q.fault_inhibit && (cnt_d == '0);
  end

  // history and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_speed_q <= '0;
      prev_load_q  <= '0;
      cnt_q        <= '0;
      res_vld_q    <= 1'b0;
    end else begin
      if (advance) begin
        prev_speed_q <= prev_speed_d;
        prev_load_q  <= ev_q.air_load;
        cnt_q        <= cnt_d;
        res_vld_q    <= 1'b1;
      end else if (m_axis_tready_i) begin
        res_vld_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q.speed_stable  <= spd_ok;
      res_q.load_stable   <= load_ok;
      res_q.engine_stable <= (cnt_d == '0);
      res_q.stable_count  <= cnt_d;
      res_q.adapt_enable  <= adapt;
    end
  end

  assign m_axis_tvalid_o = res_vld_q;
  assign m_axis_tdata_o  = {{(OutDataW-$bits(result_t)){1'b0}}, res_q};

endmodule

[design/opsq_chk.sv]
// ----------------------------------------------------------------------------
// opsq_chk
// Port-level checks for the stability qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module opsq_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [opsq_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import opsq_pkg::*;

  result_t res;
  assign res = result_t'(m_axis_tdata_o[$bits(result_t)-1:0]);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> res.stable_count <= CountMax)
    else $error("stable count above limit");

  a_eng_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> res.engine_stable == (res.stable_count == '0))
    else $error("engine stable flag disagrees with count");

  a_adapt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && res.adapt_enable |-> res.engine_stable)
    else $error("adaptation enabled while engine unstable");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("request side blocked with empty result register");

endmodule

bind operating_point_stability_qualifier_unit opsq_chk u_opsq_chk (.*);
